### rtl/mfes_pkg.sv
// shared types and constants for the flag/escape byte stuffer
`default_nettype none
package mfes_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG_PAT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG_LEN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_PAT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_LEN     = 3'd4;

  localparam logic DIR_STUFF   = 1'b0;
  localparam logic DIR_UNSTUFF = 1'b1;

  typedef enum logic [1:0] {
    SEL_BYTE = 2'd0,
    SEL_ESC  = 2'd1,
    SEL_FLAG = 2'd2
  } pat_sel_e;

  typedef struct packed {
    logic accept;
    logic plan_hdr;
    logic plan_dec;
    logic plan_tail;
    logic emit;
    logic flush;
    logic end_frame;
  } dp_cmd_t;

  typedef struct packed {
    logic dir;
    logic in_frame;
    logic item_last;
    logic dec_needed;
    logic emit_ok;
    logic emit_last;
    logic hold_v;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

### rtl/mfes_if.sv
// valid/ready channel interfaces for input and result items
`default_nettype none
interface mfes_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;
  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink (input valid, input data_byte, input frame_last, output ready);
endinterface

interface mfes_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       run_last;
  modport source (output valid, output out_byte, output frame_end, output run_last,
                  input ready);
  modport sink (input valid, input out_byte, input frame_end, input run_last,
                output ready);
endinterface
`default_nettype wire

### rtl/mfes_ctrl.sv
// sequencing state machine for the stuffer
`default_nettype none
module mfes_ctrl
  import mfes_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EMIT  = 5'b00010,
    S_DEC   = 5'b00100,
    S_TAIL  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.dir == DIR_STUFF && !sts_i.in_frame) begin
            cmd_o.plan_hdr = 1'b1;
            state_d        = S_EMIT;
          end else begin
            state_d = S_DEC;
          end
        end
      end
      S_EMIT: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.dec_needed) begin
          cmd_o.plan_dec = 1'b1;
          state_d        = S_EMIT;
        end else if (sts_i.item_last && sts_i.dir == DIR_STUFF) begin
          cmd_o.plan_tail = 1'b1;
          state_d         = S_TAIL;
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_TAIL: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!sts_i.hold_v || sts_i.out_free) begin
          cmd_o.flush     = 1'b1;
          cmd_o.end_frame = sts_i.item_last;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### rtl/mfes_dp.sv
// datapath: config registers, match window, trailer delay, emit and output stages
`default_nettype none
module mfes_dp
  import mfes_pkg::*;
#(
  parameter int MaxPat = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [7:0]            in_byte_i,
  input  wire logic                  in_last_i,
  input  wire dp_cmd_t               cmd_i,
  output dp_sts_t                    sts_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic                       out_frame_end_o,
  output logic                       out_run_last_o
);

  localparam int Depth = 2 * MaxPat;
  localparam int LW    = $clog2(MaxPat + 1);
  localparam int CW    = $clog2(Depth + 1);
  localparam int IW    = $clog2(Depth);
  localparam int TW    = (MaxPat > 1) ? $clog2(MaxPat) : 1;

  // configuration
  logic        dir_q;
  logic [31:0] flag_pat_q, esc_pat_q;
  logic [2:0]  flag_len_q, esc_len_q;

  // frame state
  logic [7:0]    win_q [Depth];
  logic [7:0]    win_d [Depth];
  logic [CW-1:0] wfill_q, wfill_d;
  logic          in_frame_q, in_frame_d;
  logic [LW-1:0] hskip_q, hskip_d;
  logic [7:0]    td_q [MaxPat];
  logic [7:0]    td_d [MaxPat];
  logic [LW-1:0] tfill_q, tfill_d;
  logic [LW-1:0] eskip_q, eskip_d;
  logic          ilast_q;

  // emit plan
  pat_sel_e      cur_sel_q, cur_sel_d, nxt_sel_q, nxt_sel_d;
  logic [LW-1:0] cur_len_q, cur_len_d, nxt_len_q, nxt_len_d;
  logic [TW-1:0] k_q, k_d;
  logic [7:0]    pbyte_q, pbyte_d;

  // hold and output stages
  logic       hold_v_q;
  logic [7:0] hold_q;
  logic       out_v_q;
  logic [7:0] out_byte_q;
  logic       out_fe_q, out_rl_q;

  logic [LW-1:0] fl, el;
  logic          out_free, emit_last;
  logic [7:0]    emit_byte;

  function automatic logic [LW-1:0] eff_len(input logic [2:0] v);
    logic [LW-1:0] r;
    if (v == 3'd0) r = LW'(1);
    else if (32'(v) > 32'(MaxPat)) r = LW'(MaxPat);
    else r = LW'(v);
    return r;
  endfunction

  function automatic logic match_at(input logic [CW-1:0] off, input logic [31:0] pat,
                                    input logic [LW-1:0] len);
    logic        ok;
    logic [CW:0] pos;
    ok = ({1'b0, off} + (CW+1)'(len)) <= {1'b0, wfill_q};
    for (int k = 0; k < MaxPat; k++) begin
      pos = {1'b0, off} + (CW+1)'(k);
      if (k < int'(len)) begin
        if (pos >= (CW+1)'(Depth)) ok = 1'b0;
        else if (win_q[pos[IW-1:0]] != pat[8*k +: 8]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  assign fl = eff_len(flag_len_q);
  assign el = eff_len(esc_len_q);

  // decision for the byte at the head of the window
  logic          esc0, flg0, flge, dec_needed;
  logic [CW-1:0] need, rem, kk;
  pat_sel_e      p_sel0, p_sel1;
  logic [LW-1:0] p_len0, p_len1;
  logic [CW-1:0] p_drop;
  logic          p_setskip;
  logic [LW-1:0] p_skip;

  always_comb begin
    esc0 = match_at('0, esc_pat_q, el);
    flg0 = match_at('0, flag_pat_q, fl);
    flge = match_at(CW'(el), flag_pat_q, fl);
    if (dir_q == DIR_STUFF) need = (fl > el) ? CW'(fl) : CW'(el);
    else need = CW'(el) + CW'(fl);
    dec_needed = (wfill_q >= need) || (ilast_q && wfill_q != '0);
    rem = wfill_q - CW'(el);
    kk  = (CW'(el) < rem) ? CW'(el) : rem;
    p_sel0    = SEL_BYTE;
    p_len0    = LW'(1);
    p_sel1    = SEL_BYTE;
    p_len1    = '0;
    p_drop    = CW'(1);
    p_setskip = 1'b0;
    p_skip    = '0;
    if (dir_q == DIR_STUFF) begin
      if (esc0) begin
        p_sel0 = SEL_ESC;  p_len0 = el;
        p_sel1 = SEL_ESC;  p_len1 = el;
        p_drop = CW'(el);
      end else if (flg0) begin
        p_sel0 = SEL_ESC;  p_len0 = el;
        p_sel1 = SEL_FLAG; p_len1 = fl;
        p_drop = CW'(fl);
      end
    end else if (esc0) begin
      if (flge) begin
        p_sel0 = SEL_FLAG; p_len0 = fl;
        p_drop = CW'(el) + CW'(fl);
      end else begin
        // lone escape: also skip the next escape-length bytes
        p_sel0    = SEL_ESC; p_len0 = el;
        p_drop    = CW'(el) + kk;
        p_setskip = 1'b1;
        p_skip    = el - LW'(kk);
      end
    end
  end

  assign out_free  = !out_v_q || out_ready_i;
  assign emit_last = ((LW'(k_q) + LW'(1)) == cur_len_q) && (nxt_len_q == '0);

  always_comb begin
    case (cur_sel_q)
      SEL_ESC:  emit_byte = esc_pat_q[{k_q, 3'b000} +: 8];
      SEL_FLAG: emit_byte = flag_pat_q[{k_q, 3'b000} +: 8];
      default:  emit_byte = pbyte_q;
    endcase
  end

  // frame state and plan updates
  logic          fresh;
  logic [LW-1:0] hs, tf, es;
  logic [CW-1:0] wf;
  logic [7:0]    old_b;

  always_comb begin
    win_d      = win_q;
    wfill_d    = wfill_q;
    in_frame_d = in_frame_q;
    hskip_d    = hskip_q;
    td_d       = td_q;
    tfill_d    = tfill_q;
    eskip_d    = eskip_q;
    cur_sel_d  = cur_sel_q;
    cur_len_d  = cur_len_q;
    nxt_sel_d  = nxt_sel_q;
    nxt_len_d  = nxt_len_q;
    k_d        = k_q;
    pbyte_d    = pbyte_q;
    fresh      = !in_frame_q;
    hs         = fresh ? fl : hskip_q;
    tf         = fresh ? '0 : tfill_q;
    es         = fresh ? '0 : eskip_q;
    wf         = fresh ? '0 : wfill_q;
    old_b      = td_q[0];

    if (cfg_we_i && cfg_idx_i <= CFG_ESC_LEN || cmd_i.end_frame) begin
      in_frame_d = 1'b0;
      wfill_d    = '0;
      hskip_d    = '0;
      tfill_d    = '0;
      eskip_d    = '0;
    end else if (cmd_i.accept) begin
      in_frame_d = 1'b1;
      hskip_d    = hs;
      tfill_d    = tf;
      eskip_d    = es;
      wfill_d    = wf;
      if (dir_q == DIR_STUFF) begin
        if (wf < CW'(Depth)) begin
          win_d[wf[IW-1:0]] = in_byte_i;
          wfill_d = wf + CW'(1);
        end
      end else if (hs != '0) begin
        hskip_d = hs - LW'(1);
      end else if (tf < fl) begin
        td_d[TW'(tf)] = in_byte_i;
        tfill_d = tf + LW'(1);
      end else begin
        for (int i = 0; i < MaxPat - 1; i++) td_d[i] = td_q[i + 1];
        td_d[TW'(fl - LW'(1))] = in_byte_i;
        if (es != '0) begin
          eskip_d = es - LW'(1);
        end else if (wf < CW'(Depth)) begin
          win_d[wf[IW-1:0]] = old_b;
          wfill_d = wf + CW'(1);
        end
      end
    end

    if (cmd_i.plan_hdr || cmd_i.plan_tail) begin
      cur_sel_d = SEL_FLAG;
      cur_len_d = fl;
      nxt_len_d = '0;
      k_d       = '0;
    end else if (cmd_i.plan_dec) begin
      cur_sel_d = p_sel0;
      cur_len_d = p_len0;
      nxt_sel_d = p_sel1;
      nxt_len_d = p_len1;
      k_d       = '0;
      pbyte_d   = win_q[0];
      for (int i = 0; i < Depth; i++) begin
        if ((CW+1)'(i) + {1'b0, p_drop} < (CW+1)'(Depth)) win_d[i] = win_q[i + int'(p_drop)];
      end
      wfill_d = wfill_q - p_drop;
      if (p_setskip) eskip_d = p_skip;
    end else if (cmd_i.emit) begin
      if ((LW'(k_q) + LW'(1)) == cur_len_q) begin
        k_d = '0;
        if (nxt_len_q != '0) begin
          cur_sel_d = nxt_sel_q;
          cur_len_d = nxt_len_q;
          nxt_len_d = '0;
        end
      end else begin
        k_d = k_q + TW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q      <= DIR_STUFF;
      flag_pat_q <= 32'h0000_007E;
      flag_len_q <= 3'd1;
      esc_pat_q  <= 32'h0000_007D;
      esc_len_q  <= 3'd1;
      wfill_q    <= '0;
      in_frame_q <= 1'b0;
      hskip_q    <= '0;
      tfill_q    <= '0;
      eskip_q    <= '0;
      cur_len_q  <= '0;
      nxt_len_q  <= '0;
      k_q        <= '0;
      hold_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DIRECTION: dir_q      <= cfg_data_i[0];
          CFG_FLAG_PAT:  flag_pat_q <= cfg_data_i;
          CFG_FLAG_LEN:  flag_len_q <= cfg_data_i[2:0];
          CFG_ESC_PAT:   esc_pat_q  <= cfg_data_i;
          CFG_ESC_LEN:   esc_len_q  <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      wfill_q    <= wfill_d;
      in_frame_q <= in_frame_d;
      hskip_q    <= hskip_d;
      tfill_q    <= tfill_d;
      eskip_q    <= eskip_d;
      cur_len_q  <= cur_len_d;
      nxt_len_q  <= nxt_len_d;
      k_q        <= k_d;
      if (cmd_i.emit) begin
        hold_v_q <= 1'b1;
      end else if (cmd_i.flush) begin
        hold_v_q <= 1'b0;
      end
      if ((cmd_i.emit || cmd_i.flush) && hold_v_q) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q     <= win_d;
    td_q      <= td_d;
    cur_sel_q <= cur_sel_d;
    nxt_sel_q <= nxt_sel_d;
    pbyte_q   <= pbyte_d;
    if (cmd_i.accept) begin
      ilast_q <= in_last_i;
    end
    if (cmd_i.emit) hold_q <= emit_byte;
    // the held byte is the last one of the item only at flush
    if ((cmd_i.emit || cmd_i.flush) && hold_v_q) begin
      out_byte_q <= hold_q;
      out_rl_q   <= cmd_i.flush;
      out_fe_q   <= cmd_i.flush && ilast_q;
    end
  end

  assign sts_o.dir        = dir_q;
  assign sts_o.in_frame   = in_frame_q;
  assign sts_o.item_last  = ilast_q;
  assign sts_o.dec_needed = dec_needed;
  assign sts_o.emit_ok    = !hold_v_q || out_free;
  assign sts_o.emit_last  = emit_last;
  assign sts_o.hold_v     = hold_v_q;
  assign sts_o.out_free   = out_free;

  assign out_valid_o     = out_v_q;
  assign out_byte_o      = out_byte_q;
  assign out_frame_end_o = out_fe_q;
  assign out_run_last_o  = out_rl_q;

endmodule
`default_nettype wire

### rtl/multibyte_flag_escape_stuffer.sv
// top level of the multibyte flag/escape byte stuffer and unstuffer
//
//  channel   dir  handshake        payload
//  in_i      in   valid/ready      data_byte[7:0], frame_last
//  out_o     out  valid/ready      out_byte[7:0], frame_end, run_last
//  cfg       in   cfg_we_i         cfg_idx_i[2:0], cfg_data_i[31:0]
//
// one item at a time: an accept step, the opening flag at the start of a stuffed frame,
// then per match decision a decision step and its emitted bytes, a check step once no
// decision is due, the closing flag after the frame's last item when stuffing, and a
// flush step
// reset clears the frame state and loads the default flag 0x7E and escape 0x7D
// a stalled output holds the emit sequencer; a result register parts both sides
`default_nettype none
module multibyte_flag_escape_stuffer
  import mfes_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  mfes_in_if.sink                    in_i,
  mfes_out_if.source                 out_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mfes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mfes_dp #(
    .MaxPat (MAX_PATTERN_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_byte_i       (in_i.data_byte),
    .in_last_i       (in_i.frame_last),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .out_byte_o      (out_o.out_byte),
    .out_frame_end_o (out_o.frame_end),
    .out_run_last_o  (out_o.run_last)
  );

endmodule
`default_nettype wire

### rtl/mfes_checker.sv
// port-level checks for the stuffer, bound to the top level
`default_nettype none
module mfes_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       frame_end_i,
  input wire logic       run_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(frame_end_i) && $stable(run_last_i))
    else $error("stalled result item changed");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !frame_end_i || run_last_i)
    else $error("frame end on a result that is not the item's last");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while one is in work");

  a_reset_out: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind multibyte_flag_escape_stuffer mfes_checker u_mfes_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .frame_end_i (out_o.frame_end),
  .run_last_i  (out_o.run_last)
);
`default_nettype wire
